@@ rtl/stereo_ping_pong_delay_core_assert.svh @@
// Assertion macros shared by the stereo ping-pong delay RTL.
`ifndef STEREO_PING_PONG_DELAY_CORE_ASSERT_SVH
`define STEREO_PING_PONG_DELAY_CORE_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define SPPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge out of reset.
`define SPPD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ rtl/sppd_pkg.sv @@
// Package: sizes, register codes, types and arithmetic helpers of the ping-pong delay.
`default_nettype none

package sppd_pkg;

  // Line memory geometry and sample format
  localparam int LINE_DEPTH  = 65536;
  localparam int SAMPLE_BITS = 24;
  localparam int ADDR_BITS   = $clog2(LINE_DEPTH);

  // Configuration registers
  localparam int CFG_BITS = 16;
  localparam int CMP_BITS = ((ADDR_BITS > CFG_BITS) ? ADDR_BITS : CFG_BITS) + 1;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_DELAY    = 2'd0;
  localparam reg_idx_t REG_FEEDBACK = 2'd1;
  localparam reg_idx_t REG_MIX      = 2'd2;

  localparam logic [CFG_BITS-1:0] DELAY_RESET    = 16'd24000;
  localparam logic [CFG_BITS-1:0] FEEDBACK_RESET = 16'd16384;
  localparam logic [CFG_BITS-1:0] MIX_RESET      = 16'd16384;

  // Q1.15 gains: unity needs 16 magnitude bits plus a sign bit
  localparam int Q_SHIFT   = 15;
  localparam int GAIN_BITS = CFG_BITS + 1;
  localparam logic [CFG_BITS-1:0] Q_ONE        = 16'd32768;
  localparam logic [CFG_BITS-1:0] BYPASS_BELOW = 16'd33;

  // Product and accumulation widths
  localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS;
  localparam int MIX_BITS  = PROD_BITS + 1;

  // Result queue
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS = FIFO_PTR_BITS + 1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [GAIN_BITS-1:0]   gain_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [MIX_BITS-1:0]    acc_t;

  typedef struct packed {
    sample_t left;
    sample_t right;
  } pair_t;

  localparam acc_t RND_HALF   = acc_t'(1) <<< (Q_SHIFT - 1);
  localparam acc_t SAMPLE_MAX = (acc_t'(1) <<< (SAMPLE_BITS - 1)) - acc_t'(1);
  localparam acc_t SAMPLE_MIN = -(acc_t'(1) <<< (SAMPLE_BITS - 1));

  // Q1.15 rounding, half up: floor((x + 2^14) / 2^15)
  function automatic acc_t rnd_q15(input acc_t x);
    acc_t s;
    s = x + RND_HALF;
    return s >>> Q_SHIFT;
  endfunction

  // Clip to the signed sample range
  function automatic sample_t sat_sample(input acc_t x);
    sample_t r;
    if (x > SAMPLE_MAX) begin
      r = SAMPLE_MAX[SAMPLE_BITS-1:0];
    end else if (x < SAMPLE_MIN) begin
      r = SAMPLE_MIN[SAMPLE_BITS-1:0];
    end else begin
      r = x[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/sppd_ram.sv @@
// Generic single-clock RAM: one write port, one read port with registered read data.
`default_nettype none

module sppd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write, and read-before-write on a same-address access
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/stereo_ping_pong_delay_core.sv @@
// Top level of the stereo ping-pong feedback delay.
`default_nettype none

`include "stereo_ping_pong_delay_core_assert.svh"

// Stereo ping-pong delay. Each input item is one stereo sample pair and yields
// one output pair. Sustained rate is one item per clock while the output side
// does not stall. The one exception: with a delay of one sample, an item cannot
// be taken in the cycle right after a previous item, because its delayed sample
// is the value that previous item is still computing (multiply, then round and
// saturate, in two stages), so such items cannot be taken back to back. The two
// line memories can be written at one address and read at another in the same
// cycle. They have no clearing pass: a fill pointer makes entries not yet
// written since reset read as zero, so the block takes items straight out of
// reset. A four-entry result queue lets input continue while results wait on
// out_stall_i. Configuration writes are always ready.
module stereo_ping_pong_delay_core
  import sppd_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // input items
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [SAMPLE_BITS-1:0] left_in_i,
  input  wire logic [SAMPLE_BITS-1:0] right_in_i,
  // result items
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic      [SAMPLE_BITS-1:0] left_out_o,
  output logic      [SAMPLE_BITS-1:0] right_out_o,
  // configuration writes
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [1:0]             cfg_index_i,
  input  wire logic [CFG_BITS-1:0]    cfg_data_i
);

  localparam logic [ADDR_BITS-1:0] LAST_IDX   = ADDR_BITS'(LINE_DEPTH - 1);
  localparam logic [ADDR_BITS:0]   DEPTH_EXT  = (ADDR_BITS + 1)'(LINE_DEPTH);
  localparam logic [CMP_BITS-1:0]  DELAY_MAX  = CMP_BITS'(LINE_DEPTH - 1);
  localparam logic [CMP_BITS-1:0]  DELAY_ONE  = CMP_BITS'(1);
  localparam logic [FIFO_CNT_BITS-1:0] FIFO_FULL = FIFO_CNT_BITS'(FIFO_DEPTH);

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [CFG_BITS-1:0] delay_q, feedback_q, mix_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q    <= DELAY_RESET;
      feedback_q <= FEEDBACK_RESET;
      mix_q      <= MIX_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (reg_idx_t'(cfg_index_i))
        REG_DELAY:    delay_q    <= cfg_data_i;
        REG_FEEDBACK: feedback_q <= cfg_data_i;
        REG_MIX:      mix_q      <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // Derived gains and delay
  gain_t               fb_gain, mix_gain, dry_gain;
  logic                bypass;
  logic [CMP_BITS-1:0] delay_ext, delay_clamp;
  logic [ADDR_BITS-1:0] delay_a;
  logic                delay_is_one;

  always_comb begin
    fb_gain  = (feedback_q > Q_ONE) ? gain_t'(Q_ONE) : gain_t'(feedback_q);
    mix_gain = (mix_q > Q_ONE) ? gain_t'(Q_ONE) : gain_t'(mix_q);
    dry_gain = gain_t'(Q_ONE) - mix_gain;
    bypass   = (mix_q < BYPASS_BELOW);

    delay_ext = CMP_BITS'(delay_q);
    if (delay_ext == '0) begin
      delay_clamp = DELAY_ONE;
    end else if (delay_ext > DELAY_MAX) begin
      delay_clamp = DELAY_MAX;
    end else begin
      delay_clamp = delay_ext;
    end
    delay_a      = delay_clamp[ADDR_BITS-1:0];
    delay_is_one = (delay_clamp == DELAY_ONE);
  end

  // ---------------------------------------------------------------------------
  // Pipeline and queue state
  logic                     v1_q, wr1_q, filled1_q;
  sample_t                  xl1_q, xr1_q;
  logic [ADDR_BITS-1:0]     wa1_q, ra1_q;

  logic                     v2_q, wr2_q;
  sample_t                  xl2_q, xr2_q;
  logic [ADDR_BITS-1:0]     wa2_q;
  prod_t                    pwl2_q, pwr2_q, pxl2_q, pdl2_q, pxr2_q, pdr2_q;

  logic [ADDR_BITS-1:0]     wi_q;
  logic                     wrapped_q;

  logic                     fwd_vld_q;
  logic [ADDR_BITS-1:0]     fwd_addr_q;
  sample_t                  fwd_l_q, fwd_r_q;

  pair_t                    fifo_q [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] fifo_wp_q, fifo_rp_q;
  logic [FIFO_CNT_BITS-1:0] fifo_cnt_q;

  // ---------------------------------------------------------------------------
  // Input acceptance: queue credits and read-after-write interlock
  logic [FIFO_CNT_BITS-1:0] credits;
  logic                     hazard, accept, wr_new;

  always_comb begin
    credits    = FIFO_CNT_BITS'(v1_q) + FIFO_CNT_BITS'(v2_q) + fifo_cnt_q;
    hazard     = v1_q && wr1_q && delay_is_one;
    in_stall_o = hazard || (credits >= FIFO_FULL);
    accept     = in_valid_i && !in_stall_o;
    wr_new     = !bypass;
  end

  // Read address: write pointer minus delay, modulo the line depth
  logic [ADDR_BITS:0]   rd_sum;
  logic [ADDR_BITS-1:0] rd_addr, wi_next;
  logic                 rd_filled;

  always_comb begin
    if (wi_q >= delay_a) begin
      rd_sum = {1'b0, wi_q} - {1'b0, delay_a};
    end else begin
      rd_sum = {1'b0, wi_q} + DEPTH_EXT - {1'b0, delay_a};
    end
    rd_addr   = rd_sum[ADDR_BITS-1:0];
    rd_filled = wrapped_q || (rd_addr < wi_q);
    wi_next   = (wi_q == LAST_IDX) ? '0 : wi_q + ADDR_BITS'(1);
  end

  // Write pointer and fill tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wi_q      <= '0;
      wrapped_q <= 1'b0;
    end else if (accept && wr_new) begin
      wi_q <= wi_next;
      if (wi_q == LAST_IDX) begin
        wrapped_q <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Line memories
  logic                 ram_we;
  sample_t              wl_d, wr_d;
  logic [SAMPLE_BITS-1:0] ram_l_rdata, ram_r_rdata;

  assign ram_we = v2_q && wr2_q;

  sppd_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (LINE_DEPTH)
  ) u_left_line (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wa2_q),
    .wdata_i (wl_d),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (ram_l_rdata)
  );

  sppd_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (LINE_DEPTH)
  ) u_right_line (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wa2_q),
    .wdata_i (wr_d),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (ram_r_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage 1 registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      wr1_q     <= wr_new;
      filled1_q <= rd_filled;
      xl1_q     <= sample_t'(left_in_i);
      xr1_q     <= sample_t'(right_in_i);
      wa1_q     <= wi_q;
      ra1_q     <= rd_addr;
    end
  end

  // Stage 1: forward the write that landed with this read, mask unwritten entries
  logic    fwd_hit;
  sample_t dl, dr;

  always_comb begin
    fwd_hit = fwd_vld_q && (fwd_addr_q == ra1_q);
    if (fwd_hit) begin
      dl = fwd_l_q;
      dr = fwd_r_q;
    end else if (filled1_q) begin
      dl = sample_t'(ram_l_rdata);
      dr = sample_t'(ram_r_rdata);
    end else begin
      dl = '0;
      dr = '0;
    end
  end

  // Stage 1 multiplies, registered into stage 2
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      wr2_q  <= wr1_q;
      xl2_q  <= xl1_q;
      xr2_q  <= xr1_q;
      wa2_q  <= wa1_q;
      pwl2_q <= prod_t'(dr) * prod_t'(fb_gain);
      pwr2_q <= prod_t'(dl) * prod_t'(fb_gain);
      pxl2_q <= prod_t'(xl1_q) * prod_t'(dry_gain);
      pdl2_q <= prod_t'(dl) * prod_t'(mix_gain);
      pxr2_q <= prod_t'(xr1_q) * prod_t'(dry_gain);
      pdr2_q <= prod_t'(dr) * prod_t'(mix_gain);
    end
  end

  // Stage 2: round, add, saturate; write-back and result
  pair_t res_d;

  always_comb begin
    wl_d = sat_sample(acc_t'(xl2_q) + rnd_q15(acc_t'(pwl2_q)));
    wr_d = sat_sample(acc_t'(xr2_q) + rnd_q15(acc_t'(pwr2_q)));
    if (wr2_q) begin
      res_d.left  = sat_sample(rnd_q15(acc_t'(pxl2_q) + acc_t'(pdl2_q)));
      res_d.right = sat_sample(rnd_q15(acc_t'(pxr2_q) + acc_t'(pdr2_q)));
    end else begin
      res_d.left  = xl2_q;
      res_d.right = xr2_q;
    end
  end

  // Last write, for the read issued at the same edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_vld_q <= 1'b0;
    end else if (ram_we) begin
      fwd_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      fwd_addr_q <= wa2_q;
      fwd_l_q    <= wl_d;
      fwd_r_q    <= wr_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue
  logic fifo_push, fifo_pop;

  assign fifo_push   = v2_q;
  assign out_valid_o = (fifo_cnt_q != '0);
  assign fifo_pop    = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fifo_wp_q  <= '0;
      fifo_rp_q  <= '0;
      fifo_cnt_q <= '0;
    end else begin
      if (fifo_push) begin
        fifo_wp_q <= fifo_wp_q + FIFO_PTR_BITS'(1);
      end
      if (fifo_pop) begin
        fifo_rp_q <= fifo_rp_q + FIFO_PTR_BITS'(1);
      end
      if (fifo_push && !fifo_pop) begin
        fifo_cnt_q <= fifo_cnt_q + FIFO_CNT_BITS'(1);
      end else if (!fifo_push && fifo_pop) begin
        fifo_cnt_q <= fifo_cnt_q - FIFO_CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fifo_push) begin
      fifo_q[fifo_wp_q] <= res_d;
    end
  end

  assign left_out_o  = fifo_q[fifo_rp_q].left;
  assign right_out_o = fifo_q[fifo_rp_q].right;

  // ---------------------------------------------------------------------------
  // Assertions
  `SPPD_NEVER(a_fifo_overflow, fifo_push && !fifo_pop && (fifo_cnt_q == FIFO_FULL), "result queue overflow")
  `SPPD_NEVER(a_credit_bound, credits > FIFO_FULL, "items in flight exceed queue space")
  `SPPD_NEVER(a_raw_interlock, v1_q && wr1_q && ram_we && (ra1_q == wa2_q), "read missed an in-flight write")
  `SPPD_ASSERT(a_ptr_hold, !(accept && wr_new) |=> $stable(wi_q), "write pointer moved without a write item")

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for the stereo ping-pong delay core.
module testbench;
  import sppd_pkg::*;

  // Index that maps to no register; writes to it must be dropped
  localparam reg_idx_t REG_UNUSED = 2'd3;

  localparam sample_t SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  localparam int RANDOM_ITEMS = 1400;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_GAP     = 8;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DIR_ROWS     = 36;

  typedef enum bit {ROW_PAIR, ROW_REG} row_kind_e;

  // One line of the directed table: a sample pair or a register write
  typedef struct packed {
    row_kind_e           kind;
    reg_idx_t            idx;
    logic [CFG_BITS-1:0] data;
    sample_t             left;
    sample_t             right;
    bit                  fixed;
    pair_t               want;
  } step_row_t;

  // Expected output typed into the table, carried along with each item
  typedef struct packed {
    bit    fixed;
    pair_t val;
  } preset_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  sample_t             left_in_i;
  sample_t             right_in_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [SAMPLE_BITS-1:0] left_out_o;
  logic [SAMPLE_BITS-1:0] right_out_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  reg_idx_t            cfg_index_i;
  logic [CFG_BITS-1:0] cfg_data_i;

  stereo_ping_pong_delay_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .left_in_i   (left_in_i),
    .right_in_i  (right_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .left_out_o  (left_out_o),
    .right_out_o (right_out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Echo line state, pointer and register copies
  sample_t             left_echo  [LINE_DEPTH];
  sample_t             right_echo [LINE_DEPTH];
  int                  echo_ptr;
  logic [CFG_BITS-1:0] dly_reg;
  logic [CFG_BITS-1:0] fb_reg;
  logic [CFG_BITS-1:0] mix_reg;

  pair_t     owed_q [$];
  preset_t   preset_q [$];
  step_row_t directed [DIR_ROWS];

  int mismatches    = 0;
  int pairs_checked = 0;
  int reg_writes    = 0;
  int holds_done    = 0;
  int cycle_cnt     = 0;
  bit in_idle_on    = 1'b0;
  bit out_idle_on   = 1'b0;
  bit hold_out_req  = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Q1.15 rounding, half up
  function automatic longint q15_round(input longint v);
    return (v + 64'sd16384) >>> 15;
  endfunction

  function automatic longint clip_sample(input longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  // Read both lines behind the pointer, write the cross-fed pair, return the mix
  function automatic void ping_pong_step(input sample_t xl, input sample_t xr,
                                         output pair_t y);
    longint fb;
    longint mx;
    longint dl;
    longint dr;
    int     d;
    int     rd;
    fb = (fb_reg > Q_ONE) ? longint'(Q_ONE) : longint'(fb_reg);
    mx = (mix_reg > Q_ONE) ? longint'(Q_ONE) : longint'(mix_reg);
    if (mix_reg < BYPASS_BELOW) begin
      y.left  = xl;
      y.right = xr;
      return;
    end
    d = int'(dly_reg);
    if (d < 1) d = 1;
    if (d > LINE_DEPTH - 1) d = LINE_DEPTH - 1;
    rd = (echo_ptr + LINE_DEPTH - d) % LINE_DEPTH;
    dl = longint'(left_echo[rd]);
    dr = longint'(right_echo[rd]);
    left_echo[echo_ptr]  = sample_t'(clip_sample(longint'(xl) + q15_round(dr * fb)));
    right_echo[echo_ptr] = sample_t'(clip_sample(longint'(xr) + q15_round(dl * fb)));
    echo_ptr = (echo_ptr + 1) % LINE_DEPTH;
    y.left  = sample_t'(clip_sample(q15_round(longint'(xl) * (32768 - mx) + dl * mx)));
    y.right = sample_t'(clip_sample(q15_round(longint'(xr) * (32768 - mx) + dr * mx)));
  endfunction

  // Mostly back to back, sometimes a short pause, rarely a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0: return SMAX;
      1: return SMIN;
      2, 3: return sample_t'($urandom_range(0, 512)) - sample_t'(256);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic step_row_t pair_row(input sample_t l, input sample_t r);
    step_row_t s;
    s = '0;
    s.kind  = ROW_PAIR;
    s.left  = l;
    s.right = r;
    return s;
  endfunction

  function automatic step_row_t known_row(input sample_t l, input sample_t r,
                                          input sample_t wl, input sample_t wr);
    step_row_t s;
    s = pair_row(l, r);
    s.fixed      = 1'b1;
    s.want.left  = wl;
    s.want.right = wr;
    return s;
  endfunction

  function automatic step_row_t reg_row(input reg_idx_t idx, input logic [CFG_BITS-1:0] v);
    step_row_t s;
    s = '0;
    s.kind = ROW_REG;
    s.idx  = idx;
    s.data = v;
    return s;
  endfunction

  // Offer one pair; valid stays high after acceptance unless a gap follows
  task automatic send_pair(input sample_t l, input sample_t r, input bit fixed,
                           input pair_t want);
    int      gap;
    preset_t p;
    gap = in_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    p.fixed = fixed;
    p.val   = want;
    preset_q.push_back(p);
    in_valid_i <= 1'b1;
    left_in_i  <= l;
    right_in_i <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Stop offering, wait for every owed result, then let the pipe settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    // the scoreboard logs the last accepted item at the edge just passed
    @(posedge clk_i);
    while (owed_q.size() != 0) @(posedge clk_i);
    repeat (IDLE_GAP) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_BITS-1:0] v, input bit last);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (last) cfg_valid_i <= 1'b0;
    case (idx)
      REG_DELAY:    dly_reg = v;
      REG_FEEDBACK: fb_reg  = v;
      REG_MIX:      mix_reg = v;
      default: ;
    endcase
    reg_writes++;
  endtask

  // Accepted items feed the echo model; accepted results are checked in order
  always @(posedge clk_i) begin : scoreboard
    pair_t   want;
    preset_t p;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        p = preset_q.pop_front();
        ping_pong_step(left_in_i, right_in_i, want);
        if (p.fixed) want = p.val;
        owed_q.push_back(want);
      end
      if (out_valid_o && !out_stall_i) begin
        if (owed_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got left %0d right %0d",
                   $time, $signed(left_out_o), $signed(right_out_o));
          mismatches++;
        end else begin
          want = owed_q.pop_front();
          pairs_checked++;
          if (left_out_o !== want.left) begin
            $display("%0t: left_out expected %0d, got %0d",
                     $time, want.left, $signed(left_out_o));
            mismatches++;
          end
          if (right_out_o !== want.right) begin
            $display("%0t: right_out expected %0d, got %0d",
                     $time, want.right, $signed(right_out_o));
            mismatches++;
          end
        end
      end
    end
  end

  // Output back-pressure, with an occasional long hold-off on request
  initial begin : result_backpressure
    int stall_cnt;
    stall_cnt = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (stall_cnt > 0) begin
        stall_cnt--;
      end else if (hold_out_req) begin
        hold_out_req = 1'b0;
        holds_done++;
        out_stall_i <= 1'b1;
        stall_cnt = HOLD_CYCLES;
      end else begin
        stall_cnt = out_idle_on ? pick_gap() : 0;
        out_stall_i <= (stall_cnt > 0);
        if (stall_cnt > 0) stall_cnt--;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int                  i;
    int                  n;
    int                  phase;
    int                  directed_sent;
    int                  random_sent;
    bit                  unk;
    logic [CFG_BITS-1:0] d;
    logic [CFG_BITS-1:0] f;
    logic [CFG_BITS-1:0] m;

    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    left_in_i   <= '0;
    right_in_i  <= '0;
    out_stall_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= REG_DELAY;
    cfg_data_i  <= '0;

    for (i = 0; i < LINE_DEPTH; i++) begin
      left_echo[i]  = '0;
      right_echo[i] = '0;
    end
    echo_ptr = 0;
    dly_reg  = DELAY_RESET;
    fb_reg   = FEEDBACK_RESET;
    mix_reg  = MIX_RESET;
    directed_sent = 0;
    random_sent   = 0;

    // Lines read zero after reset; half mix gives floor((x + 1) / 2)
    directed = '{
      known_row(0, 0, 0, 0),
      known_row(SMAX, SMIN, 4194304, -4194304),
      known_row(1, -1, 1, 0),
      known_row(-1, 1, 0, 1),
      // shortest delay, unity feedback, fully wet: saturating feedback
      reg_row(REG_DELAY, 1),
      reg_row(REG_FEEDBACK, 32768),
      reg_row(REG_MIX, 32768),
      pair_row(SMAX, SMIN),
      pair_row(SMAX, SMIN),
      pair_row(0, 0),
      pair_row(SMIN, SMAX),
      // bypass passes the input through untouched
      reg_row(REG_MIX, 0),
      known_row(SMAX, SMIN, SMAX, SMIN),
      known_row('h123456, -5, 'h123456, -5),
      reg_row(REG_MIX, 32),
      known_row(7, -7, 7, -7),
      // zero delay acts as one, gain above unity clamps, lowest active mix
      reg_row(REG_DELAY, 0),
      reg_row(REG_FEEDBACK, 65535),
      reg_row(REG_MIX, 33),
      pair_row(100, -100),
      pair_row(SMIN, SMIN),
      pair_row(SMAX, -1),
      // longest delay, no feedback, mix above unity clamps
      reg_row(REG_DELAY, 65535),
      reg_row(REG_FEEDBACK, 0),
      reg_row(REG_MIX, 65535),
      pair_row(SMAX, SMAX),
      pair_row(-2, 2),
      // a write to the unused index must not reach any register
      reg_row(REG_UNUSED, 0),
      pair_row(5, 6),
      reg_row(REG_DELAY, 2),
      reg_row(REG_FEEDBACK, 32768),
      reg_row(REG_MIX, 16384),
      pair_row(SMAX, SMIN),
      pair_row(SMIN, SMAX),
      pair_row(12345, -12345),
      pair_row(SMAX, SMAX)
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    for (i = 0; i < DIR_ROWS; i++) begin
      if (directed[i].kind == ROW_REG) begin
        if (i == 0 || directed[i-1].kind != ROW_REG) wait_idle();
        write_reg(directed[i].idx, directed[i].data,
                  (i == DIR_ROWS - 1) || (directed[i+1].kind != ROW_REG));
      end else begin
        send_pair(directed[i].left, directed[i].right, directed[i].fixed, directed[i].want);
        directed_sent++;
      end
    end

    // Random phases, each with its own setting and idling mix
    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      wait_idle();
      case ($urandom_range(0, 9))
        0: d = 0;
        1: d = 1;
        2: d = 16'hFFFF;
        3, 4: d = $urandom_range(2, 8);
        5, 6, 7: d = $urandom_range(1, 64);
        default: d = $urandom_range(1, 2000);
      endcase
      case ($urandom_range(0, 9))
        0: f = 0;
        1: f = 32768;
        2: f = $urandom_range(32769, 65535);
        default: f = $urandom_range(0, 32768);
      endcase
      case ($urandom_range(0, 9))
        0: m = $urandom_range(0, 32);
        1: m = 33;
        2: m = 32768;
        3: m = $urandom_range(32769, 65535);
        default: m = $urandom_range(33, 32768);
      endcase
      // first phase runs the one-sample delay flat out
      if (phase == 0) begin
        d = 1;
        if (m < BYPASS_BELOW) m = 32768;
      end
      unk = ($urandom_range(0, 3) == 0);
      write_reg(REG_DELAY, d, 1'b0);
      write_reg(REG_FEEDBACK, f, 1'b0);
      write_reg(REG_MIX, m, !unk);
      if (unk) write_reg(REG_UNUSED, $urandom_range(0, 65535), 1'b1);

      in_idle_on  = (phase != 0) && ($urandom_range(0, 9) < 7);
      out_idle_on = (phase != 0) && ($urandom_range(0, 9) < 7);
      // long output hold-off while items keep coming, so the input stalls
      if (phase == 1) begin
        in_idle_on   = 1'b0;
        hold_out_req = 1'b1;
      end
      n = $urandom_range(60, 160);
      repeat (n) begin
        send_pair(pick_sample(), pick_sample(), 1'b0, '0);
        random_sent++;
      end
      phase++;
    end

    wait_idle();
    repeat (16) @(posedge clk_i);

    $display("Checked %0d result pairs from %0d directed and %0d random items",
             pairs_checked, directed_sent, random_sent);
    $display("over %0d settings, %0d register writes and %0d long output hold-offs.",
             phase + 1, reg_writes, holds_done);
    if (mismatches == 0 && owed_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/sppd_pkg.sv
rtl/sppd_ram.sv
rtl/stereo_ping_pong_delay_core.sv
dv/testbench.sv
